/* rtl/packet_signature_matcher_defines.svh */
// Assertion macros shared by the signature matcher RTL.
`ifndef PACKET_SIGNATURE_MATCHER_DEFINES_SVH
`define PACKET_SIGNATURE_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/psm_pkg.sv */
// Shared types and field constants of the packet signature matcher.
package psm_pkg;

	// Request kinds carried on the input tuser.
	typedef enum logic [1:0] {
		REQ_PAT_BYTE = 2'd0,
		REQ_SIG_HDR  = 2'd1,
		REQ_PAYLOAD  = 2'd2
	} req_t;

	localparam int BYTE_W     = 8;
	localparam int PROTO_W    = 3;
	localparam int SLOT_FLD_W = 5;
	localparam int POS_FLD_W  = 5;
	localparam int LEN_FLD_W  = 6;
	localparam int OFFSET_W   = 16;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 32;
	localparam int TUSER_W    = 2;

endpackage

/* rtl/packet_signature_matcher.sv */
// A load request is taken while idle; a payload byte keeps s_tready low until its slot walk ends,
// and the result of a last byte is registered into the output once its walk ends and the output is free.
// Throughput: the walk reads one slot per cycle through the single read port of the pattern
// and header memories and stops at the first match or the best slot. A result still waiting
// for m_tready holds the end of the next packet's last walk. Reset empties every slot, clears
// the packet state and enables detection; pattern bytes are undefined until written.
module packet_signature_matcher #(
	parameter int              NUM_SLOTS     = 32,
	parameter int              PATTERN_BYTES = 32,
	parameter longint unsigned OFFSET_LIMIT  = 65535
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// sig_slot, byte_pos, data_byte, pattern_len, protocol, zero fill
	input  logic [psm_pkg::IN_TDATA_W-1:0]     s_tdata,
	// req_type
	input  logic [psm_pkg::TUSER_W-1:0]        s_tuser,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// detected, matched_slot, first_offset, packet_protocol, zero fill
	output logic [psm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	`include "packet_signature_matcher_defines.svh"

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SCNT_W = $clog2(NUM_SLOTS + 1);
	localparam int POS_W  = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
	localparam int LEN_W  = $clog2(PATTERN_BYTES + 1);
	localparam longint unsigned CNT_CAP = OFFSET_LIMIT + PATTERN_BYTES + 1;
	localparam int CNT_W  = $clog2(CNT_CAP + 1);
	localparam longint unsigned OUT_LIM = (OFFSET_LIMIT > 65535) ? 65535 : OFFSET_LIMIT;
	localparam int OW     = psm_pkg::OFFSET_W;
	localparam int PW     = psm_pkg::PROTO_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t              state_q;
	psm_pkg::req_t       req;
	logic [4:0]          sig_slot;
	logic [4:0]          byte_pos;
	logic [7:0]          data_byte;
	logic [5:0]          pattern_len;
	logic [PW-1:0]       protocol;
	logic                accept;
	logic                slot_ok;
	logic                pos_ok;
	logic                pat_we;
	logic                hdr_we;
	logic                pay_acc;
	logic [LEN_W-1:0]    wlen;

	logic [CNT_W-1:0]    bytes_q;
	logic [PW-1:0]       cur_proto_q;
	logic                best_found_q;
	logic [SLOT_W-1:0]   best_slot_q;
	logic [OW-1:0]       best_off_q;
	logic                last_q;
	logic                en_q;
	logic [SCNT_W-1:0]   rd_idx_q;
	logic                pend_s2;
	logic [SLOT_W-1:0]   slot_s2;
	logic                out_valid_q;
	logic [psm_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic [SCNT_W-1:0]   scan_lim;
	logic                issue;
	logic                hit;
	logic [LEN_W-1:0]    rlen;
	logic [PW-1:0]       rproto;
	logic [PATTERN_BYTES*psm_pkg::BYTE_W-1:0] rrow;
	logic                win_eq;
	logic [CNT_W-1:0]    start;
	logic                len_fits;
	logic                start_ok;
	logic [OW-1:0]       off_sat;
	logic                out_free;
	logic                out_load;
	logic                det;

	// Request field unpacking.
	always_comb begin
		req         = psm_pkg::req_t'(s_tuser);
		sig_slot    = s_tdata[4:0];
		byte_pos    = s_tdata[9:5];
		data_byte   = s_tdata[17:10];
		pattern_len = s_tdata[23:18];
		protocol    = s_tdata[26:24];
	end

	// Load decode; out-of-range slots and positions are dropped.
	always_comb begin
		accept  = s_tvalid && s_tready;
		slot_ok = {4'b0000, sig_slot} < 9'(NUM_SLOTS);
		pos_ok  = {4'b0000, byte_pos} < 9'(PATTERN_BYTES);
		pat_we  = accept && (req == psm_pkg::REQ_PAT_BYTE) && slot_ok && pos_ok;
		hdr_we  = accept && (req == psm_pkg::REQ_SIG_HDR) && slot_ok;
		pay_acc = accept && (req == psm_pkg::REQ_PAYLOAD);
		wlen    = ({3'b000, pattern_len} > 9'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES)
			: LEN_W'(pattern_len);
	end

	// Slot walk control: stop at the current best slot or at the first hit.
	always_comb begin
		scan_lim = best_found_q ? SCNT_W'(best_slot_q) : SCNT_W'(NUM_SLOTS);
		start    = bytes_q - CNT_W'(rlen);
		len_fits = bytes_q >= CNT_W'(rlen);
		start_ok = start <= CNT_W'(OFFSET_LIMIT);
		hit      = pend_s2 && (rlen != '0) && (rproto == cur_proto_q) && len_fits &&
			start_ok && win_eq;
		issue    = (state_q == ST_SCAN) && !hit && (rd_idx_q < scan_lim);
		off_sat  = (start > CNT_W'(OUT_LIM)) ? OW'(OUT_LIM) : OW'(start);
		out_free = !out_valid_q || m_tready;
		out_load = (state_q == ST_FINISH) && last_q && out_free;
		det      = en_q && best_found_q;
	end

	psm_pattern_mem #(
		.ROWS  (NUM_SLOTS),
		.LANES (PATTERN_BYTES)
	) u_pat (
		.clk   (clk),
		.we    (pat_we),
		.waddr (SLOT_W'(sig_slot)),
		.wlane (POS_W'(byte_pos)),
		.wdata (data_byte),
		.re    (issue),
		.raddr (rd_idx_q[SLOT_W-1:0]),
		.rdata (rrow)
	);

	psm_slot_table #(
		.SLOTS (NUM_SLOTS),
		.LEN_W (LEN_W)
	) u_hdr (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (hdr_we),
		.waddr  (SLOT_W'(sig_slot)),
		.wlen   (wlen),
		.wproto (protocol),
		.re     (issue),
		.raddr  (rd_idx_q[SLOT_W-1:0]),
		.rlen   (rlen),
		.rproto (rproto)
	);

	psm_window #(
		.P     (PATTERN_BYTES),
		.LEN_W (LEN_W)
	) u_win (
		.clk  (clk),
		.push (pay_acc),
		.din  (data_byte),
		.len  (rlen),
		.row  (rrow),
		.eq   (win_eq)
	);

	// Sequencer, packet state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bytes_q      <= '0;
			cur_proto_q  <= '0;
			best_found_q <= 1'b0;
			best_slot_q  <= '0;
			best_off_q   <= '0;
			last_q       <= 1'b0;
			en_q         <= 1'b1;
			rd_idx_q     <= '0;
			pend_s2      <= 1'b0;
			slot_s2      <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			pend_s2 <= issue;
			slot_s2 <= rd_idx_q[SLOT_W-1:0];
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pay_acc) begin
						if (bytes_q == '0) begin
							cur_proto_q <= protocol;
						end
						if (bytes_q < CNT_W'(CNT_CAP)) begin
							bytes_q <= bytes_q + 1'b1;
						end
						last_q   <= s_tlast;
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						best_found_q <= 1'b1;
						best_slot_q  <= slot_s2;
						best_off_q   <= off_sat;
						state_q      <= ST_FINISH;
					end else if (!issue && !pend_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_data_q   <= {7'b0000000, cur_proto_q,
							det ? best_off_q : {OW{1'b0}},
							det ? psm_pkg::SLOT_FLD_W'(best_slot_q)
								: {psm_pkg::SLOT_FLD_W{1'b0}},
							det};
						bytes_q      <= '0;
						best_found_q <= 1'b0;
						best_slot_q  <= '0;
						best_off_q   <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A hit only ever comes from a slot below the walk limit.
	`PSM_ASSERT_NOW(a_hit_below_limit, clk, arst_n, hit, SCNT_W'(slot_s2) < scan_lim, "hit past limit")
	// Memory read data is only consumed while walking the table.
	`PSM_ASSERT_NOW(a_pend_in_scan, clk, arst_n, pend_s2, state_q == ST_SCAN, "read outside walk")
	// Delivering a result clears the per-packet state.
	`PSM_ASSERT_NEXT(a_packet_cleared, clk, arst_n, out_load, (bytes_q == '0) && out_valid_q, "no clear")

endmodule

/* rtl/psm_pattern_mem.sv */
// Pattern byte memory: one row per signature slot, byte-lane writes, registered row read.
module psm_pattern_mem #(
	parameter int ROWS  = 32,
	parameter int LANES = 32,
	localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1,
	localparam int LW   = (LANES > 1) ? $clog2(LANES) : 1
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [AW-1:0]                       waddr,
	input  logic [LW-1:0]                       wlane,
	input  logic [psm_pkg::BYTE_W-1:0]          wdata,
	input  logic                                re,
	input  logic [AW-1:0]                       raddr,
	output logic [LANES*psm_pkg::BYTE_W-1:0]    rdata
);

	logic [LANES*psm_pkg::BYTE_W-1:0] mem [ROWS];

	// Single byte-lane write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wlane*psm_pkg::BYTE_W +: psm_pkg::BYTE_W] <= wdata;
		end
	end

	// Whole-row registered read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/psm_slot_table.sv */
// Slot header memory: length and protocol per slot, with valid bits cleared at reset.
module psm_slot_table #(
	parameter int SLOTS = 32,
	parameter int LEN_W = 6,
	localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [LEN_W-1:0]              wlen,
	input  logic [psm_pkg::PROTO_W-1:0]   wproto,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [LEN_W-1:0]              rlen,
	output logic [psm_pkg::PROTO_W-1:0]   rproto
);

	logic [LEN_W-1:0]            len_mem   [SLOTS];
	logic [psm_pkg::PROTO_W-1:0] proto_mem [SLOTS];
	logic [SLOTS-1:0]            valid_q;

	// Header writes; a slot reads as empty until its first header write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			len_mem[waddr]   <= wlen;
			proto_mem[waddr] <= wproto;
		end
	end

	// Registered read, masked to zero for slots never written.
	always_ff @(posedge clk) begin
		if (re) begin
			rlen   <= valid_q[raddr] ? len_mem[raddr] : '0;
			rproto <= valid_q[raddr] ? proto_mem[raddr] : '0;
		end
	end

endmodule

/* rtl/psm_window.sv */
// Payload window of the most recent bytes and its aligned compare against one pattern row.
module psm_window #(
	parameter int P     = 32,
	parameter int LEN_W = 6
) (
	input  logic                             clk,
	input  logic                             push,
	input  logic [psm_pkg::BYTE_W-1:0]       din,
	input  logic [LEN_W-1:0]                 len,
	input  logic [P*psm_pkg::BYTE_W-1:0]     row,
	output logic                             eq
);

	localparam int WW = P * psm_pkg::BYTE_W;

	logic [WW-1:0]    win_q;
	logic [WW-1:0]    shifted;
	logic [LEN_W-1:0] sh;
	logic [P-1:0]     lane_ok;

	// Newest byte enters at the top lane, oldest drops out of lane zero.
	generate
		if (P > 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (push) begin
					win_q <= {din, win_q[WW-1:psm_pkg::BYTE_W]};
				end
			end
		end else begin : g_single
			always_ff @(posedge clk) begin
				if (push) begin
					win_q <= din;
				end
			end
		end
	endgenerate

	// Bring the last len bytes down to lane zero, then compare lane by lane.
	always_comb begin
		sh      = LEN_W'(P) - len;
		shifted = win_q >> {sh, 3'b000};
		for (int j = 0; j < P; j++) begin
			lane_ok[j] = (LEN_W'(j) >= len) ||
				(row[j*psm_pkg::BYTE_W +: psm_pkg::BYTE_W] ==
				 shifted[j*psm_pkg::BYTE_W +: psm_pkg::BYTE_W]);
		end
		eq = &lane_ok;
	end

endmodule

/* verif/tb.sv */
// Self-checking testbench for the packet signature matcher: table loads, packets, detect enable.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 32;
	localparam int PBYTES = 32;
	localparam longint unsigned OFF_LIMIT = 65535;
	localparam longint unsigned COUNT_CAP = OFF_LIMIT + PBYTES + 1;
	// Pad that lets a payload byte's worst-case slot walk finish, plus margin.
	localparam int LATENCY_PAD = 48;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 880;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] slot;
		logic [4:0] pos;
		logic [7:0] data;
		logic [5:0] len;
		logic [2:0] proto;
		logic       last;
	} sig_req_t;

	typedef struct packed {
		logic        hit;
		logic [4:0]  slot;
		logic [15:0] offset;
		logic [2:0]  proto;
	} report_t;

	// Tracks the signature table and packet state, and holds the reports still owed.
	class match_tracker;
		bit [7:0] pat_mem [SLOTS][PBYTES];
		bit [5:0] slot_len [SLOTS];
		bit [2:0] slot_proto [SLOTS];
		bit [7:0] window [PBYTES];
		int unsigned win_ptr;
		longint unsigned seen;
		bit [2:0] pkt_proto;
		bit found;
		bit [4:0] best_slot;
		longint unsigned best_off;
		bit enable;
		report_t pending_reports [$];
		int unsigned mismatches;
		int unsigned reports_checked;
		int unsigned detections;

		function new();
			enable = 1'b1;
		endfunction

		task report_mismatch(input string what);
			mismatches++;
			$display("mismatch at %0t: %s", $realtime, what);
		endtask

		// True when the newest len payload bytes equal the slot's pattern.
		function bit window_hit(input int s, input int len);
			int j;
			int w;
			for (j = 0; j < len; j++) begin
				w = (win_ptr + PBYTES - len + j) % PBYTES;
				if (window[w] != pat_mem[s][j])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		// One payload byte: shift it in, rescan the table, and close the packet on its last byte.
		function void scan_payload(input sig_req_t r);
			int s;
			int len;
			longint unsigned start;
			report_t rep;
			if (seen == 0)
				pkt_proto = r.proto;
			window[win_ptr] = r.data;
			win_ptr = (win_ptr + 1) % PBYTES;
			if (seen < COUNT_CAP)
				seen++;
			for (s = 0; s < SLOTS; s++) begin
				len = slot_len[s];
				if (len == 0 || slot_proto[s] != pkt_proto)
					continue;
				if (found && best_slot <= s)
					break;
				if (seen < len)
					continue;
				start = seen - len;
				if (start > OFF_LIMIT)
					continue;
				if (window_hit(s, len)) begin
					found = 1'b1;
					best_slot = s[4:0];
					best_off = start;
					break;
				end
			end
			if (!r.last)
				return;
			rep = '0;
			if (enable && found) begin
				rep.hit = 1'b1;
				rep.slot = best_slot;
				rep.offset = (best_off > 64'hFFFF) ? 16'hFFFF : best_off[15:0];
			end
			rep.proto = pkt_proto;
			pending_reports = {pending_reports, rep};
			seen = 0;
			found = 1'b0;
			best_slot = '0;
			best_off = 0;
		endfunction

		// Called for every accepted request, in acceptance order.
		function void note_request(input sig_req_t r);
			unique case (r.kind)
				psm_pkg::REQ_PAT_BYTE: begin
					pat_mem[r.slot][r.pos] = r.data;
				end
				psm_pkg::REQ_SIG_HDR: begin
					slot_len[r.slot] = (r.len > PBYTES) ? 6'(PBYTES) : r.len;
					slot_proto[r.slot] = r.proto;
				end
				psm_pkg::REQ_PAYLOAD: begin
					scan_payload(r);
				end
				default: begin
				end
			endcase
		endfunction

		// Compare one accepted report with the oldest one owed.
		task check_report(input logic [psm_pkg::OUT_TDATA_W-1:0] t);
			report_t want;
			report_t got;
			got.hit = t[0];
			got.slot = t[5:1];
			got.offset = t[21:6];
			got.proto = t[24:22];
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected report %h", t));
			end else begin
				want = pending_reports.pop_front();
				reports_checked++;
				if (want.hit)
					detections++;
				if (got.hit !== want.hit)
					report_mismatch($sformatf("detected %b, want %b", got.hit, want.hit));
				if (got.slot !== want.slot)
					report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
				if (got.offset !== want.offset)
					report_mismatch($sformatf("offset %0d, want %0d", got.offset, want.offset));
				if (got.proto !== want.proto)
					report_mismatch($sformatf("protocol %0d, want %0d", got.proto, want.proto));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [psm_pkg::IN_TDATA_W-1:0] s_tdata;
	logic [psm_pkg::TUSER_W-1:0] s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [psm_pkg::OUT_TDATA_W-1:0] m_tdata;

	match_tracker tracker = new();

	// Which pattern bytes the stimulus has written, so no header exposes an unwritten byte.
	bit pat_written [SLOTS][PBYTES];
	int unsigned accepted_items;
	bit steady_tx;
	int quiet = 0;

	packet_signature_matcher #(
		.NUM_SLOTS(SLOTS),
		.PATTERN_BYTES(PBYTES),
		.OFFSET_LIMIT(OFF_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: too long without any request or report moving ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
			$display("tb: errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Report side: alternating ready runs and stalls, mostly short stalls with a few long ones.
	initial begin : report_sink
		int run;
		int roll;
		bit ready_now;
		run = 0;
		ready_now = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				tracker.check_report(m_tdata);
			if (arst_n && run == 0) begin
				ready_now = !ready_now;
				roll = $urandom_range(0, 99);
				if (ready_now)
					run = (roll < 8) ? 300 : $urandom_range(1, 24);
				else if (roll < 60)
					run = 1;
				else if (roll < 90)
					run = $urandom_range(2, 4);
				else if (roll < 98)
					run = $urandom_range(5, 15);
				else
					run = $urandom_range(20, 60);
			end
			if (run > 0)
				run--;
			m_tready <= ready_now;
		end
	end

	function automatic int tx_gap();
		int roll;
		if (steady_tx)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_byte(input bit narrow);
		logic [7:0] few [4];
		few = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
		return narrow ? few[$urandom_range(0, 3)] : 8'($urandom_range(0, 255));
	endfunction

	function automatic int written_prefix(input int s);
		int n;
		n = 0;
		while (n < PBYTES && pat_written[s][n])
			n++;
		return n;
	endfunction

	// Send one request and wait for it to be taken. Called at a rising edge.
	task automatic send_request(input logic [1:0] kind, input logic [4:0] slot,
			input logic [4:0] pos, input logic [7:0] data, input logic [5:0] len,
			input logic [2:0] proto, input logic last);
		sig_req_t r;
		int gap;
		r = '{kind, slot, pos, data, len, proto, last};
		gap = tx_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, proto, len, data, pos, slot};
		s_tuser <= kind;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		tracker.note_request(r);
		if (kind != REQ_UNKNOWN)
			accepted_items++;
	endtask

	task automatic write_pattern(input int s, input int p, input logic [7:0] b);
		send_request(psm_pkg::REQ_PAT_BYTE, s[4:0], p[4:0], b, 6'($urandom_range(0, 63)),
			3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
		pat_written[s][p] = 1'b1;
	endtask

	task automatic write_header(input int s, input int len, input int proto);
		send_request(psm_pkg::REQ_SIG_HDR, s[4:0], 5'($urandom_range(0, 31)),
			8'($urandom_range(0, 255)), len[5:0], proto[2:0], 1'($urandom_range(0, 1)));
	endtask

	task automatic send_payload(input logic [7:0] b, input int proto, input bit last);
		send_request(psm_pkg::REQ_PAYLOAD, 5'($urandom_range(0, 31)),
			5'($urandom_range(0, 31)), b, 6'($urandom_range(0, 63)), proto[2:0], last);
	endtask

	// Stop sending, wait for every owed report, then let a walk in progress finish.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (tracker.pending_reports.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic set_detect(input bit value);
		drain_pipeline();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.enable = value;
	endtask

	// Load a whole signature: its pattern bytes first, then the header.
	task automatic load_signature(input int s);
		int n;
		int i;
		int roll;
		int proto;
		int len_field;
		bit narrow;
		roll = $urandom_range(0, 99);
		n = (roll < 70) ? $urandom_range(1, 4) : (roll < 90) ? $urandom_range(5, 16) :
			$urandom_range(17, 32);
		proto = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, 7);
		narrow = $urandom_range(0, 1);
		for (i = 0; i < n; i++)
			write_pattern(s, i, pick_byte(narrow));
		len_field = n;
		// Full-length patterns also exercise the saturation of oversized lengths.
		if (n == PBYTES && $urandom_range(0, 1))
			len_field = $urandom_range(33, 63);
		write_header(s, len_field, proto);
	endtask

	// Load noise: a stray pattern byte, or a header over bytes already written.
	task automatic load_noise();
		int s;
		int p;
		int len_field;
		s = $urandom_range(0, 31);
		if ($urandom_range(0, 1)) begin
			write_pattern(s, $urandom_range(0, 31), pick_byte($urandom_range(0, 1)));
		end else begin
			p = written_prefix(s);
			len_field = $urandom_range(0, p);
			if (p == PBYTES && $urandom_range(0, 1))
				len_field = $urandom_range(33, 63);
			write_header(s, len_field, $urandom_range(0, 7));
		end
	endtask

	// A packet of random bytes, usually with a stored pattern planted somewhere in it.
	task automatic random_packet();
		logic [7:0] pkt [$];
		int n;
		int s;
		int i;
		int plen;
		int at;
		int tries;
		int proto;
		bit narrow;
		narrow = ($urandom_range(0, 2) == 0);
		n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 45);
		for (i = 0; i < n; i++)
			pkt = {pkt, pick_byte(narrow)};
		s = $urandom_range(0, 31);
		for (tries = 0; tries < 16 && tracker.slot_len[s] == 0; tries++)
			s = $urandom_range(0, 31);
		proto = (tracker.slot_len[s] != 0 && $urandom_range(0, 4) != 0) ?
			int'(tracker.slot_proto[s]) : $urandom_range(0, 7);
		if (tracker.slot_len[s] != 0 && $urandom_range(0, 9) < 7) begin
			plen = tracker.slot_len[s];
			while (pkt.size() < plen)
				pkt = {pkt, pick_byte(narrow)};
			at = $urandom_range(0, pkt.size() - plen);
			for (i = 0; i < plen; i++)
				pkt[at + i] = tracker.pat_mem[s][i];
		end
		for (i = 0; i < pkt.size(); i++) begin
			if ($urandom_range(0, 24) == 0)
				load_noise();
			// Only the first byte's protocol counts; later ones carry random tags.
			send_payload(pkt[i], (i == 0) ? proto : $urandom_range(0, 7), i == pkt.size() - 1);
		end
	endtask

	initial begin : stimulus
		int i;
		int roll;
		int unsigned random_base;
		bit went_dark;
		bit paused;
		bit woke;
		accepted_items = 0;
		steady_tx = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		s_tlast <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: field extremes, unknown request, short payload, loads mid-packet.
		set_detect(1'b1);
		send_request(REQ_UNKNOWN, 5'h1F, 5'h1F, 8'hFF, 6'h3F, 3'h7, 1'b1);
		write_pattern(31, 31, 8'hFF);
		write_pattern(0, 0, 8'h00);
		write_pattern(0, 1, 8'hFF);
		write_header(0, 2, 0);
		write_pattern(31, 0, 8'h41);
		write_header(31, 1, 7);
		write_header(4, 0, 0);
		send_payload(8'hFF, 0, 1'b0);
		send_payload(8'h00, 0, 1'b0);
		send_payload(8'hFF, 0, 1'b1);
		send_payload(8'h41, 7, 1'b1);
		// A one-byte packet cannot hold the two-byte pattern.
		send_payload(8'h00, 0, 1'b1);
		// No signature carries this protocol.
		send_payload(8'h41, 3, 1'b1);
		// Slot 2 appears between two bytes of the same packet.
		send_payload(8'h10, 7, 1'b0);
		write_pattern(2, 0, 8'h22);
		write_header(2, 1, 7);
		send_payload(8'h22, 0, 1'b1);
		// With detection off only the protocol is reported.
		set_detect(1'b0);
		send_payload(8'h41, 7, 1'b1);
		set_detect(1'b1);

		// Random part: mostly loads and packets that can match, some noise.
		for (i = 0; i < 6; i++)
			load_signature($urandom_range(0, 31));
		random_base = accepted_items;
		went_dark = 1'b0;
		paused = 1'b0;
		woke = 1'b0;
		while (accepted_items - random_base < RANDOM_ITEMS) begin
			if (!went_dark && accepted_items - random_base >= RANDOM_ITEMS / 3) begin
				set_detect(1'b0);
				went_dark = 1'b1;
			end
			if (!paused && accepted_items - random_base >= RANDOM_ITEMS / 2) begin
				drain_pipeline();
				paused = 1'b1;
			end
			if (!woke && accepted_items - random_base >= 2 * RANDOM_ITEMS / 3) begin
				set_detect(1'b1);
				woke = 1'b1;
			end
			if ($urandom_range(0, 39) == 0)
				steady_tx = !steady_tx;
			roll = $urandom_range(0, 99);
			if (roll < 55)
				random_packet();
			else if (roll < 77)
				load_signature($urandom_range(0, 31));
			else if (roll < 92)
				load_noise();
			else
				send_request(REQ_UNKNOWN, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
					8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
					3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
		end

		steady_tx = 1'b0;
		drain_pipeline();
		$display("summary: %0d requests taken, %0d packet reports checked, %0d with a detection",
			accepted_items, tracker.reports_checked, tracker.detections);
		$display("summary: detection switched off and on, loads mixed into packets, one full drain");
		if (tracker.mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl
rtl/psm_pkg.sv
rtl/psm_pattern_mem.sv
rtl/psm_slot_table.sv
rtl/psm_window.sv
rtl/packet_signature_matcher.sv
verif/tb.sv
